// ----- hdl/minv_pkg.sv -----
// shared widths, types and helpers for the 3x3 matrix inverse pipeline
package minv_pkg;

	localparam int ENTRY_W   = 16;
	localparam int PROD_W    = 2 * ENTRY_W;
	localparam int COF_W     = PROD_W + 1;
	localparam int CMAG_W    = PROD_W;
	localparam int TERM_W    = ENTRY_W + COF_W;
	localparam int SUM_W     = TERM_W + 1;
	localparam int FRAC_DROP = 16;
	localparam int DET_W     = 33;
	localparam int OUT_W     = 16;
	localparam int QBITS     = OUT_W;
	localparam int CMP_W     = DET_W + QBITS;
	localparam int MIN_DET_W = 31;
	localparam int DIV_STEPS = QBITS;

	localparam logic [MIN_DET_W-1:0] MIN_DET_RST = MIN_DET_W'(1);
	localparam logic [SUM_W-1:0]     TRUNC_BIAS  = SUM_W'((64'd1 << FRAC_DROP) - 64'd1);

	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef entry_t [2:0]              row_t;
	typedef entry_t [2:0][2:0]         mat_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [COF_W-1:0]   cof_t;
	typedef cof_t [2:0][2:0]           cof_mat_t;
	typedef logic signed [TERM_W-1:0]  term_t;
	typedef logic signed [DET_W-1:0]   det_t;
	typedef logic [DET_W-1:0]          mag_t;
	typedef logic signed [OUT_W-1:0]   out_t;

	localparam out_t OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam out_t OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct packed {
		logic [CMAG_W-1:0] rem;
		logic [QBITS-1:0]  quo;
		mag_t              mag;
		logic              neg;
		logic              zero;
		logic              ovf;
	} div_t;

	function automatic int idx_lo(int k);
		return (k == 0) ? 1 : 0;
	endfunction

	function automatic int idx_hi(int k);
		return (k == 2) ? 1 : 2;
	endfunction

endpackage

// ----- hdl/matrix_inverse_3x3_top.sv -----
// 3x3 fixed-point matrix inverse by adjugate, top level
//
// channel  direction  signals
// in       sink       in_valid, in_ready, in_r1c1 .. in_r3c3
// out      source     out_valid, out_ready, inv_r1c1 .. inv_r3c3, det_out, singular
// cfg      sink       cfg_valid, cfg_ready, min_det
//
// 23 register stages: 2 for cofactors, 3 for the determinant and singular test,
// 1 divider setup, 16 quotient bit stages, 1 output stage; one matrix per cycle unless the output stalls.
// each of the nine lanes holds a 16-bit restoring divide.
// reset clears the stage valid bits and sets min_det to 1.
// a stalled output freezes the whole pipeline; in_ready follows that stall.
module matrix_inverse_3x3_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  minv_pkg::entry_t               in_r1c1,
	input  minv_pkg::entry_t               in_r1c2,
	input  minv_pkg::entry_t               in_r1c3,
	input  minv_pkg::entry_t               in_r2c1,
	input  minv_pkg::entry_t               in_r2c2,
	input  minv_pkg::entry_t               in_r2c3,
	input  minv_pkg::entry_t               in_r3c1,
	input  minv_pkg::entry_t               in_r3c2,
	input  minv_pkg::entry_t               in_r3c3,
	output logic                           out_valid,
	input  logic                           out_ready,
	output minv_pkg::out_t                 inv_r1c1,
	output minv_pkg::out_t                 inv_r1c2,
	output minv_pkg::out_t                 inv_r1c3,
	output minv_pkg::out_t                 inv_r2c1,
	output minv_pkg::out_t                 inv_r2c2,
	output minv_pkg::out_t                 inv_r2c3,
	output minv_pkg::out_t                 inv_r3c1,
	output minv_pkg::out_t                 inv_r3c2,
	output minv_pkg::out_t                 inv_r3c3,
	output minv_pkg::det_t                 det_out,
	output logic                           singular,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [minv_pkg::MIN_DET_W-1:0] min_det
);
	import minv_pkg::*;

	localparam int DEPTH     = 6 + DIV_STEPS + 1;
	localparam int DET_DELAY = DEPTH - 5;

	logic [DEPTH-1:0]     v_q;
	logic [MIN_DET_W-1:0] min_det_q;
	logic                 en;

	mat_t     mat;
	cof_mat_t cof_s2;
	row_t     row1_s2;
	cof_mat_t cof_s5;
	det_t     det_s5;
	mag_t     mag_s5;
	logic     sing_s5;
	out_t     quo [3][3];

	det_t det_dly_q  [DET_DELAY];
	logic sing_dly_q [DET_DELAY];

	assign en        = !v_q[DEPTH-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_q[DEPTH-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q       <= '0;
			min_det_q <= MIN_DET_RST;
		end else begin
			if (en)
				v_q <= {v_q[DEPTH-2:0], in_valid};
			if (cfg_valid)
				min_det_q <= min_det;
		end
	end

	assign mat[0][0] = in_r1c1;
	assign mat[0][1] = in_r1c2;
	assign mat[0][2] = in_r1c3;
	assign mat[1][0] = in_r2c1;
	assign mat[1][1] = in_r2c2;
	assign mat[1][2] = in_r2c3;
	assign mat[2][0] = in_r3c1;
	assign mat[2][1] = in_r3c2;
	assign mat[2][2] = in_r3c3;

	minv_cof u_cof (
		.clk     (clk),
		.en      (en),
		.a       (mat),
		.cof_s2  (cof_s2),
		.row1_s2 (row1_s2)
	);

	minv_det u_det (
		.clk     (clk),
		.en      (en),
		.cof_s2  (cof_s2),
		.row1_s2 (row1_s2),
		.min_det (min_det_q),
		.cof_s5  (cof_s5),
		.det_s5  (det_s5),
		.mag_s5  (mag_s5),
		.sing_s5 (sing_s5)
	);

	// inverse entry (i,j) divides cofactor (j,i)
	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			minv_div u_div (
				.clk     (clk),
				.en      (en),
				.cof     (cof_s5[j][i]),
				.det_neg (det_s5[DET_W-1]),
				.mag     (mag_s5),
				.sing    (sing_s5),
				.quo_out (quo[i][j])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_dly_q[0]  <= det_s5;
			sing_dly_q[0] <= sing_s5;
			for (int k = 1; k < DET_DELAY; k++) begin
				det_dly_q[k]  <= det_dly_q[k-1];
				sing_dly_q[k] <= sing_dly_q[k-1];
			end
		end
	end

	assign inv_r1c1 = quo[0][0];
	assign inv_r1c2 = quo[0][1];
	assign inv_r1c3 = quo[0][2];
	assign inv_r2c1 = quo[1][0];
	assign inv_r2c2 = quo[1][1];
	assign inv_r2c3 = quo[1][2];
	assign inv_r3c1 = quo[2][0];
	assign inv_r3c2 = quo[2][1];
	assign inv_r3c3 = quo[2][2];
	assign det_out  = det_dly_q[DET_DELAY-1];
	assign singular = sing_dly_q[DET_DELAY-1];

`ifndef NO_ASSERTIONS
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> inv_r1c1 == '0 && inv_r2c2 == '0 && inv_r3c3 == '0
			&& inv_r1c2 == '0 && inv_r2c1 == '0 && inv_r3c1 == '0)
		else $error("singular result with nonzero inverse");
	a_det_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && det_out == '0 |-> singular)
		else $error("zero determinant not flagged singular");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q))
		else $error("pipeline moved during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked without output stall");
`endif

endmodule

// ----- hdl/minv_cof.sv -----
// minor products and signed cofactors, two register stages
module minv_cof (
	input  logic              clk,
	input  logic              en,
	input  minv_pkg::mat_t    a,
	output minv_pkg::cof_mat_t cof_s2,
	output minv_pkg::row_t    row1_s2
);
	import minv_pkg::*;

	prod_t p0_s1 [3][3];
	prod_t p1_s1 [3][3];
	row_t  row1_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					p0_s1[r][c] <= $signed(a[idx_lo(r)][idx_lo(c)]) *
						$signed(a[idx_hi(r)][idx_hi(c)]);
					p1_s1[r][c] <= $signed(a[idx_lo(r)][idx_hi(c)]) *
						$signed(a[idx_hi(r)][idx_lo(c)]);
				end
			end
			row1_s1 <= a[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if (((r + c) % 2) == 1)
						cof_s2[r][c] <= COF_W'($signed(p1_s1[r][c])) -
							COF_W'($signed(p0_s1[r][c]));
					else
						cof_s2[r][c] <= COF_W'($signed(p0_s1[r][c])) -
							COF_W'($signed(p1_s1[r][c]));
				end
			end
			row1_s2 <= row1_s1;
		end
	end

endmodule

// ----- hdl/minv_det.sv -----
// determinant by first-row expansion, truncation and singular test
module minv_det (
	input  logic                         clk,
	input  logic                         en,
	input  minv_pkg::cof_mat_t           cof_s2,
	input  minv_pkg::row_t               row1_s2,
	input  logic [minv_pkg::MIN_DET_W-1:0] min_det,
	output minv_pkg::cof_mat_t           cof_s5,
	output minv_pkg::det_t               det_s5,
	output minv_pkg::mag_t               mag_s5,
	output logic                         sing_s5
);
	import minv_pkg::*;

	term_t    term_s3 [3];
	cof_mat_t cof_s3;
	cof_mat_t cof_s4;
	det_t     det_s4;

	logic signed [SUM_W-1:0] sum;
	logic        [SUM_W-1:0] biased;
	mag_t                    mag;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				term_s3[j] <= $signed(row1_s2[j]) * $signed(cof_s2[0][j]);
			cof_s3 <= cof_s2;
		end
	end

	always_comb begin
		sum = SUM_W'(term_s3[0]) + SUM_W'(term_s3[1]) + SUM_W'(term_s3[2]);
		biased = sum[SUM_W-1] ? (sum + TRUNC_BIAS) : sum;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= biased[FRAC_DROP+DET_W-1:FRAC_DROP];
			cof_s4 <= cof_s3;
		end
	end

	assign mag = det_s4[DET_W-1] ? (~det_s4 + DET_W'(1)) : det_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5  <= det_s4;
			mag_s5  <= mag;
			sing_s5 <= (det_s4 == '0) || (mag < DET_W'(min_det));
			cof_s5  <= cof_s4;
		end
	end

endmodule

// ----- hdl/minv_div.sv -----
// one inverse entry: pipelined restoring divide, one quotient bit per stage
module minv_div (
	input  logic           clk,
	input  logic           en,
	input  minv_pkg::cof_t cof,
	input  logic           det_neg,
	input  minv_pkg::mag_t mag,
	input  logic           sing,
	output minv_pkg::out_t quo_out
);
	import minv_pkg::*;

	div_t div_s [DIV_STEPS+1];

	logic [COF_W-1:0] cmag;
	div_t             prep;

	function automatic div_t div_step(div_t s, int b);
		logic [CMP_W:0] sub;
		div_t           n;
		n = s;
		sub = {(CMP_W+1-CMAG_W)'(0), s.rem} - {1'b0, (CMP_W'(s.mag) << b)};
		if (!sub[CMP_W]) begin
			n.rem = sub[CMAG_W-1:0];
			n.quo[b] = 1'b1;
		end
		return n;
	endfunction

	function automatic out_t fmt(div_t s);
		logic [QBITS:0] neg_q;
		out_t           r;
		neg_q = ~{1'b0, s.quo} + (QBITS+1)'(1);
		if (s.zero)
			r = '0;
		else if (s.ovf)
			r = s.neg ? OUT_MIN : OUT_MAX;
		else if (s.neg)
			r = (s.quo > QBITS'(OUT_MAX) + QBITS'(1)) ? OUT_MIN : neg_q[OUT_W-1:0];
		else
			r = (s.quo > QBITS'(OUT_MAX)) ? OUT_MAX : s.quo;
		return r;
	endfunction

	always_comb begin
		cmag = cof[COF_W-1] ? (~cof + COF_W'(1)) : cof;
		prep.rem  = cmag[CMAG_W-1:0];
		prep.quo  = '0;
		prep.mag  = mag;
		prep.neg  = cof[COF_W-1] ^ det_neg;
		prep.zero = sing;
		prep.ovf  = CMP_W'(cmag) >= {mag, QBITS'(0)};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= prep;
			for (int k = 1; k <= DIV_STEPS; k++)
				div_s[k] <= div_step(div_s[k-1], DIV_STEPS - k);
			quo_out <= fmt(div_s[DIV_STEPS]);
		end
	end

endmodule

// ----- tb/matrix_inverse_3x3_top_test.sv -----
// self-checking testbench for the 3x3 fixed-point matrix inverse pipeline
module matrix_inverse_3x3_top_test;

	import minv_pkg::*;

	localparam int PIPE_LATENCY = 23;
	localparam logic [MIN_DET_W-1:0] THRESH_MAX = {MIN_DET_W{1'b1}};

	typedef struct packed {
		out_t [2:0][2:0] inv;
		det_t            det;
		logic            sing;
	} inverse_t;

	typedef enum int {MAT_FULL, MAT_NEAR_ID, MAT_EXTREME, MAT_RANK_LOW} mat_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	entry_t in_r1c1 = '0, in_r1c2 = '0, in_r1c3 = '0;
	entry_t in_r2c1 = '0, in_r2c2 = '0, in_r2c3 = '0;
	entry_t in_r3c1 = '0, in_r3c2 = '0, in_r3c3 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t inv_r1c1, inv_r1c2, inv_r1c3, inv_r2c1, inv_r2c2, inv_r2c3;
	out_t inv_r3c1, inv_r3c2, inv_r3c3;
	det_t det_out;
	logic singular;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [MIN_DET_W-1:0] min_det = '0;

	logic [MIN_DET_W-1:0] det_threshold = MIN_DET_RST;
	inverse_t expected_inverses[$];
	int errors = 0;
	int matrices_sent = 0;
	int results_seen = 0;
	int singular_seen = 0;
	int burst_left = 0;
	int stall_pct = 0;
	int stall_cycles = 0;

	matrix_inverse_3x3_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_r1c1(in_r1c1), .in_r1c2(in_r1c2), .in_r1c3(in_r1c3),
		.in_r2c1(in_r2c1), .in_r2c2(in_r2c2), .in_r2c3(in_r2c3),
		.in_r3c1(in_r3c1), .in_r3c2(in_r3c2), .in_r3c3(in_r3c3),
		.out_valid(out_valid), .out_ready(out_ready),
		.inv_r1c1(inv_r1c1), .inv_r1c2(inv_r1c2), .inv_r1c3(inv_r1c3),
		.inv_r2c1(inv_r2c1), .inv_r2c2(inv_r2c2), .inv_r2c3(inv_r2c3),
		.inv_r3c1(inv_r3c1), .inv_r3c2(inv_r3c2), .inv_r3c3(inv_r3c3),
		.det_out(det_out), .singular(singular),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .min_det(min_det)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("timeout");
		$display("Some tests failed");
		$finish;
	end

	function automatic inverse_t predict_inverse(mat_t m);
		longint a[3][3];
		longint cof[3][3];
		longint det_full, det_q, mag, q;
		int r0, r1, c0, c1;
		inverse_t res;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				a[i][j] = longint'(entry_t'(m[i][j]));
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				r0 = (r == 0) ? 1 : 0;
				r1 = (r == 2) ? 1 : 2;
				c0 = (c == 0) ? 1 : 0;
				c1 = (c == 2) ? 1 : 2;
				cof[r][c] = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
				if ((r + c) % 2 == 1)
					cof[r][c] = -cof[r][c];
			end
		det_full = 0;
		for (int j = 0; j < 3; j++)
			det_full += a[0][j] * cof[0][j];
		det_q = det_full / 65536;
		res.det = det_q[DET_W-1:0];
		det_q = longint'(res.det);
		mag = (det_q < 0) ? -det_q : det_q;
		res.sing = (det_q == 0) || (mag < longint'(det_threshold));
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				q = 0;
				if (!res.sing) begin
					q = cof[j][i] / det_q;
					if (q > 32767)
						q = 32767;
					if (q < -32768)
						q = -32768;
				end
				res.inv[i][j] = q[OUT_W-1:0];
			end
		return res;
	endfunction

	function automatic mat_t make_mat(entry_t e0, entry_t e1, entry_t e2, entry_t e3,
			entry_t e4, entry_t e5, entry_t e6, entry_t e7, entry_t e8);
		mat_t m;
		m[0][0] = e0; m[0][1] = e1; m[0][2] = e2;
		m[1][0] = e3; m[1][1] = e4; m[1][2] = e5;
		m[2][0] = e6; m[2][1] = e7; m[2][2] = e8;
		return m;
	endfunction

	function automatic entry_t extreme_entry();
		case ($urandom_range(0, 5))
			0: return entry_t'(16'sh7FFF);
			1: return entry_t'(16'sh8000);
			2: return entry_t'(0);
			3: return entry_t'(-1);
			4: return entry_t'(256);
			default: return entry_t'($urandom);
		endcase
	endfunction

	function automatic mat_t random_matrix(mat_kind_t kind);
		mat_t m;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				case (kind)
					MAT_NEAR_ID: m[i][j] = entry_t'((i == j ? 256 : 0)
							+ $signed($urandom_range(0, 1023)) - 512);
					MAT_EXTREME: m[i][j] = extreme_entry();
					default: m[i][j] = entry_t'($urandom);
				endcase
		if (kind == MAT_RANK_LOW)
			m[2] = m[$urandom_range(0, 1)];
		return m;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on result %0d: %s got %0d expected %0d",
			results_seen, field, got, want);
		errors++;
	endtask

	task automatic send_matrix(mat_t m);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_r1c1 <= m[0][0]; in_r1c2 <= m[0][1]; in_r1c3 <= m[0][2];
		in_r2c1 <= m[1][0]; in_r2c2 <= m[1][1]; in_r2c3 <= m[1][2];
		in_r3c1 <= m[2][0]; in_r3c2 <= m[2][1]; in_r3c3 <= m[2][2];
		do @(posedge clk); while (!in_ready);
		expected_inverses.push_back(predict_inverse(m));
		matrices_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_inverses.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_min_det(logic [MIN_DET_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		min_det <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		det_threshold = value;
	endtask

	always @(posedge clk) begin : check_result
		inverse_t got;
		inverse_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got.inv[0][0] = inv_r1c1; got.inv[0][1] = inv_r1c2; got.inv[0][2] = inv_r1c3;
			got.inv[1][0] = inv_r2c1; got.inv[1][1] = inv_r2c2; got.inv[1][2] = inv_r2c3;
			got.inv[2][0] = inv_r3c1; got.inv[2][1] = inv_r3c2; got.inv[2][2] = inv_r3c3;
			got.det = det_out;
			got.sing = singular;
			if (expected_inverses.size() == 0) begin
				$display("result transfer with nothing expected");
				errors++;
			end else begin
				want = expected_inverses.pop_front();
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						if (got.inv[i][j] !== want.inv[i][j])
							report_mismatch($sformatf("inv_r%0dc%0d", i + 1, j + 1),
								longint'(got.inv[i][j]), longint'(want.inv[i][j]));
				if (got.det !== want.det)
					report_mismatch("det_out", longint'(got.det), longint'(want.det));
				if (got.sing !== want.sing)
					report_mismatch("singular", got.sing, want.sing);
				if (want.sing)
					singular_seen++;
			end
			results_seen++;
		end
		if (stall_cycles == 0) begin
			stall_cycles = $urandom_range(50, 300);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		stall_cycles--;
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic test_reset_threshold();
		send_matrix(make_mat(256, 0, 0, 0, 256, 0, 0, 0, 256));
		send_matrix(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_matrix(make_mat(32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767));
		send_matrix(make_mat(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
		send_matrix(make_mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
		send_matrix(make_mat(-32768, 32767, -32768, 32767, -32768, 32767,
			-32768, 32767, 32767));
		send_matrix(make_mat(0, 256, 0, 0, 0, 256, 256, 0, 0));
		send_matrix(make_mat(64, 0, 0, 0, -64, 0, 0, 0, 64));
		send_matrix(make_mat(16, 0, 0, 0, 16, 0, 0, 0, 16));
		send_matrix(make_mat(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		send_matrix(make_mat(512, 128, -256, 0, -384, 96, 1024, 7, -5));
	endtask

	task automatic test_zero_threshold();
		write_min_det('0);
		send_matrix(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_matrix(make_mat(256, 512, 768, 256, 512, 768, 1, 2, 3));
		send_matrix(make_mat(16, 0, 0, 0, 16, 0, 0, 0, 16));
		send_matrix(make_mat(32767, 32767, 0, 32767, 32766, 0, 0, 0, 256));
		send_matrix(make_mat(-32768, -32768, 0, -32768, -32767, 0, 0, 0, -256));
		send_matrix(make_mat(32767, 32767, 0, 32767, 32766, 0, 0, 0, -256));
		send_matrix(make_mat(128, 0, 0, 0, 128, 0, 0, 0, 2));
	endtask

	task automatic test_max_threshold();
		write_min_det(THRESH_MAX);
		send_matrix(make_mat(256, 0, 0, 0, 256, 0, 0, 0, 256));
		send_matrix(make_mat(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
		send_matrix(make_mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
		write_min_det(31'd4096);
		send_matrix(make_mat(4096, 0, 0, 0, 4096, 0, 0, 0, 4096));
		send_matrix(make_mat(4095, 0, 0, 0, 4096, 0, 0, 0, 4096));
	endtask

	task automatic test_random_matrices();
		mat_kind_t kind;
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: write_min_det(31'd1);
				1: write_min_det('0);
				2: write_min_det(31'($urandom));
				3: write_min_det(31'($urandom_range(0, 1000)));
				4: write_min_det(31'($urandom_range(0, 2000000)));
				5: write_min_det(THRESH_MAX);
				default: write_min_det(31'($urandom_range(1, 300)));
			endcase
			repeat (150) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: kind = MAT_FULL;
					4, 5, 6: kind = MAT_NEAR_ID;
					7, 8: kind = MAT_EXTREME;
					default: kind = MAT_RANK_LOW;
				endcase
				send_matrix(random_matrix(kind));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_threshold();
		test_zero_threshold();
		test_max_threshold();
		test_random_matrices();
		wait_idle();
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		$display("covered %0d matrices, %0d results, %0d flagged singular",
			matrices_sent, results_seen, singular_seen);
		$display("threshold settings from zero to full scale, random stalls and gaps");
		if (errors == 0 && expected_inverses.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
